/* rtl/rrs_pkg.sv */
`timescale 1ns / 1ps

package rrs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int MODE_W    = 2;
    localparam int PID_W     = 8;
    localparam int BURST_W   = 16;
    localparam int TIME_W    = 32;
    localparam int ENTRY_W   = PID_W + BURST_W;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd4;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ADVANCE,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN
    } t_state;

endpackage

/* rtl/rrs_ram.sv */
`timescale 1ns / 1ps

module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rrs_front.sv */
`timescale 1ns / 1ps

module rrs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [rrs_pkg::MODE_W-1:0]     i_mode,
    input  logic [rrs_pkg::PID_W-1:0]      i_process_id,
    input  logic [rrs_pkg::BURST_W-1:0]    i_burst_time,
    output logic                           o_cmd_valid,
    output rrs_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_pop
);

    rrs_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    rrs_pkg::t_cmd w_cmd;
    logic          w_keep;
    logic          w_push;
    logic          w_pop;

    // classify the item; unknown modes are taken and dropped
    always_comb begin
        w_cmd.pid   = i_process_id;
        w_cmd.burst = i_burst_time;
        w_keep      = 1'b1;
        case (i_mode)
            rrs_pkg::MODE_LOAD:    w_cmd.op = rrs_pkg::OP_LOAD;
            rrs_pkg::MODE_ADVANCE: w_cmd.op = rrs_pkg::OP_ADVANCE;
            rrs_pkg::MODE_CLEAR:   w_cmd.op = rrs_pkg::OP_CLEAR;
            default: begin
                w_cmd.op = rrs_pkg::OP_LOAD;
                w_keep   = 1'b0;
            end
        endcase
    end

    // two-entry queue, full when the count reaches two
    assign o_in_stall  = r_cnt[1];
    assign w_push      = i_in_valid && !o_in_stall && w_keep;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

/* rtl/rrs_back.sv */
`timescale 1ns / 1ps

module rrs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrs_pkg::BURST_W-1:0]   i_cfg_wdata,
    input  logic                          i_cmd_valid,
    input  rrs_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rrs_pkg::PID_W-1:0]     o_process_id_res,
    output logic [rrs_pkg::TIME_W-1:0]    o_slice_end_time,
    output logic                          o_all_done
);

    localparam int IW = rrs_pkg::IDX_W;
    localparam int CW = rrs_pkg::CNT_W;
    localparam int BW = rrs_pkg::BURST_W;
    localparam int TW = rrs_pkg::TIME_W;

    rrs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_active, n_active;
    logic [IW-1:0]   r_next, n_next;
    logic [IW-1:0]   r_pos, n_pos;
    logic [TW-1:0]   r_time, n_time;
    logic [BW-1:0]   r_quantum;
    logic            r_out_valid, n_out_valid;
    logic [rrs_pkg::PID_W-1:0] r_pid_res, n_pid_res;
    logic [TW-1:0]   r_time_res, n_time_res;
    logic            r_done, n_done;

    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [rrs_pkg::ENTRY_W-1:0]  w_wdata;
    logic [IW-1:0]                w_raddr;
    logic [rrs_pkg::ENTRY_W-1:0]  w_rdata;
    logic [rrs_pkg::PID_W-1:0]    w_rd_id;
    logic [BW-1:0]                w_rd_rem;
    logic [BW-1:0]                w_q;
    logic [BW-1:0]                w_slice;
    logic [TW:0]                  w_sum;
    logic [TW-1:0]                w_time_sat;
    logic [IW-1:0]                w_pos_next;
    logic                         w_can_out;

    rrs_ram #(
        .WIDTH (rrs_pkg::ENTRY_W),
        .DEPTH (rrs_pkg::MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_id  = w_rdata[rrs_pkg::ENTRY_W-1:BW];
    assign w_rd_rem = w_rdata[BW-1:0];

    // zero quantum behaves as one so every slice makes progress
    assign w_q        = (r_quantum == '0) ? BW'(1) : r_quantum;
    assign w_slice    = (w_rd_rem < w_q) ? w_rd_rem : w_q;
    assign w_sum      = {1'b0, r_time} + (TW + 1)'(w_slice);
    assign w_time_sat = w_sum[TW] ? '1 : w_sum[TW-1:0];
    assign w_pos_next = ((CW'(r_pos) + CW'(1)) == r_count) ? '0 : r_pos + IW'(1);
    assign w_can_out  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_active    = r_active;
        n_next      = r_next;
        n_pos       = r_pos;
        n_time      = r_time;
        n_out_valid = r_out_valid && i_out_stall;
        n_pid_res   = r_pid_res;
        n_time_res  = r_time_res;
        n_done      = r_done;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = {w_rd_id, w_rd_rem - w_slice};
        w_raddr     = r_pos;
        case (r_state)
            rrs_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        rrs_pkg::OP_LOAD: begin
                            if (r_count < CW'(rrs_pkg::MAX_PROCS)) begin
                                w_we    = 1'b1;
                                w_waddr = r_count[IW-1:0];
                                w_wdata = {i_cmd.pid, i_cmd.burst};
                                n_count = r_count + CW'(1);
                                if (i_cmd.burst != '0) begin
                                    n_active = r_active + CW'(1);
                                end
                            end
                        end
                        rrs_pkg::OP_ADVANCE: begin
                            // nothing left means no result and no scan
                            if (r_active != '0) begin
                                n_pos   = r_next;
                                n_state = rrs_pkg::ST_FETCH;
                            end
                        end
                        rrs_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_active = '0;
                            n_next   = '0;
                            n_time   = '0;
                        end
                        default: begin
                            n_state = rrs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rrs_pkg::ST_FETCH: begin
                n_state = rrs_pkg::ST_SCAN;
            end
            rrs_pkg::ST_SCAN: begin
                if (w_rd_rem == '0) begin
                    // skip finished entry, read the following one
                    n_pos   = w_pos_next;
                    w_raddr = w_pos_next;
                end else if (w_can_out) begin
                    w_we        = 1'b1;
                    n_time      = w_time_sat;
                    n_next      = w_pos_next;
                    n_active    = r_active - ((w_rd_rem == w_slice) ? CW'(1) : CW'(0));
                    n_out_valid = 1'b1;
                    n_pid_res   = w_rd_id;
                    n_time_res  = w_time_sat;
                    n_done      = (n_active == '0);
                    n_state     = rrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrs_pkg::ST_IDLE;
            r_count     <= '0;
            r_active    <= '0;
            r_next      <= '0;
            r_pos       <= '0;
            r_time      <= '0;
            r_quantum   <= rrs_pkg::QUANTUM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_active    <= n_active;
            r_next      <= n_next;
            r_pos       <= n_pos;
            r_time      <= n_time;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid_res  <= n_pid_res;
        r_time_res <= n_time_res;
        r_done     <= n_done;
    end

    assign o_out_valid      = r_out_valid;
    assign o_process_id_res = r_pid_res;
    assign o_slice_end_time = r_time_res;
    assign o_all_done       = r_done;

endmodule

/* rtl/round_robin_slice_scheduler.sv */
`timescale 1ns / 1ps

// round-robin time-slice scheduler
// input channel (i_in_valid / o_in_stall) carries one item: mode, process id, burst time.
// mode load appends an entry (ignored when the table is full), clear empties the table
// and zeroes the time, advance runs the next entry with work left for one slice.
// only an advance that finds work produces an item on the output channel
// (o_out_valid / i_out_stall): process id, slice end time, all-done flag.
// items land in a two-entry queue; the sequencer behind it takes one at a time.
// load and clear are handled in the sequencer's idle state; an advance passes through the
// fetch and scan states, the scan skipping finished entries one per cycle through the table
// memory read port, and registers its result when it finds an entry with work left.
// a finished result waits in the output register while the receiver stalls; an advance
// that finds work then holds in its scan, the queue fills and o_in_stall rises when full.
// i_cfg_we writes the time quantum (reset 4); write it only while idle.
// reset (synchronous, active low) empties the table and queue and zeroes the time.

module round_robin_slice_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrs_pkg::BURST_W-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rrs_pkg::MODE_W-1:0]    i_mode,
    input  logic [rrs_pkg::PID_W-1:0]     i_process_id,
    input  logic [rrs_pkg::BURST_W-1:0]   i_burst_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rrs_pkg::PID_W-1:0]     o_process_id_res,
    output logic [rrs_pkg::TIME_W-1:0]    o_slice_end_time,
    output logic                          o_all_done
);

    logic          w_cmd_valid;
    rrs_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;

    rrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_process_id (i_process_id),
        .i_burst_time (i_burst_time),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    rrs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd_valid      (w_cmd_valid),
        .i_cmd            (w_cmd),
        .o_cmd_pop        (w_cmd_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_process_id_res (o_process_id_res),
        .o_slice_end_time (o_slice_end_time),
        .o_all_done       (o_all_done)
    );

endmodule

/* rtl/rrs_checker.sv */
`timescale 1ns / 1ps

module rrs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rrs_pkg::PID_W-1:0]     o_process_id_res,
    input logic [rrs_pkg::TIME_W-1:0]    o_slice_end_time,
    input logic                          o_all_done
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_process_id_res)
            && $stable(o_slice_end_time) && $stable(o_all_done))
        else $error("stalled result changed");

    // every slice lasts at least one time unit, so a result never shows time zero
    a_time_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_slice_end_time != '0)
        else $error("slice end time is zero");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind round_robin_slice_scheduler rrs_checker u_rrs_checker (.*);
